// File: design/rit_pkg.sv
`timescale 1ns / 1ps
package rit_pkg;

  typedef logic [3:0] opcode_t;
  typedef logic [3:0] status_t;
  typedef logic [2:0] thr_state_t;
  typedef logic [2:0] wake_t;

  localparam opcode_t OP_CREATE       = 4'd0;
  localparam opcode_t OP_CREATE_ADM   = 4'd1;
  localparam opcode_t OP_START        = 4'd2;
  localparam opcode_t OP_EXIT         = 4'd3;
  localparam opcode_t OP_SEND         = 4'd4;
  localparam opcode_t OP_RECEIVE      = 4'd5;
  localparam opcode_t OP_REPLY        = 4'd6;
  localparam opcode_t OP_CANCEL_CALL  = 4'd7;
  localparam opcode_t OP_CANCEL_RECV  = 4'd8;
  localparam opcode_t OP_EXPIRE_RECV  = 4'd9;
  localparam opcode_t OP_TAKE_EXPIRY  = 4'd10;

  localparam status_t ST_OK           = 4'd0;
  localparam status_t ST_INVALID      = 4'd1;
  localparam status_t ST_EXISTS       = 4'd2;
  localparam status_t ST_FULL         = 4'd3;
  localparam status_t ST_UNKNOWN      = 4'd4;
  localparam status_t ST_NOT_RUNNABLE = 4'd5;
  localparam status_t ST_SELF         = 4'd6;
  localparam status_t ST_NOT_WAITING  = 4'd7;
  localparam status_t ST_NOT_AWAITING = 4'd8;

  localparam thr_state_t TS_ADMITTED  = 3'd0;
  localparam thr_state_t TS_READY     = 3'd1;
  localparam thr_state_t TS_SEND_BLK  = 3'd2;
  localparam thr_state_t TS_REPLY_BLK = 3'd3;
  localparam thr_state_t TS_RECV_BLK  = 3'd4;

  localparam wake_t WK_NONE        = 3'd0;
  localparam wake_t WK_PEER_EXITED = 3'd1;
  localparam wake_t WK_RETIRED     = 3'd2;
  localparam wake_t WK_DEADLINE    = 3'd3;
  localparam wake_t WK_REPLIED     = 3'd4;

endpackage

// File: design/rendezvous_ipc_thread_table.sv
`timescale 1ns / 1ps
// each input word runs a lookup scan over every slot of the slot ram, a decide step,
// then a read-modify-write sweep over the slot ram and a finish step; one word is in
// work at a time, and the next input word is taken while a finished result still
// waits in the output register
// rst_n (synchronous, active low) clears the slot valid bits, the live count,
// fallback priority and the handshake state; slot ram contents need no clearing
module rendezvous_ipc_thread_table #(
  parameter int SLOT_COUNT = 16,
  parameter int ID_BITS    = 16,
  localparam int CNT_W  = $clog2(SLOT_COUNT + 1),
  localparam int IN_W   = 4 + 2 * ID_BITS + 8,
  localparam int IN_DW  = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W  = 4 + ID_BITS + CNT_W + 1 + 3 + 3 + 8 + 8 + CNT_W,
  localparam int OUT_DW = ((OUT_W + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  // opcode, thread_a, thread_b, priority_req
  input  logic [IN_DW-1:0]  in_tdata,
  input  logic              in_tvalid,
  output logic              in_tready,
  // status, result_thread, released_count, expiry_taken, thread_state,
  // wake_reason, base_priority, effective_priority, live_threads
  output logic [OUT_DW-1:0] out_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  logic              cfg_wr_en,
  input  logic [7:0]        cfg_wr_data
);
  import rit_pkg::*;

  localparam int IDX_W = $clog2(SLOT_COUNT);

  // one slot record as held in the ram; occupancy lives in valid_r
  typedef struct packed {
    logic [ID_BITS-1:0] id;
    thr_state_t         state;
    logic [ID_BITS-1:0] partner;
    wake_t              wake;
    logic [7:0]         base;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // sequencer phases
  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_SCAN   = 5'b00010,
    PH_DECIDE = 5'b00100,
    PH_SWEEP  = 5'b01000,
    PH_FIN    = 5'b10000
  } phase_t;

  phase_t phase_r, phase_nxt;

  // latched input word
  opcode_t            op_r;
  logic [ID_BITS-1:0] a_r, b_r;
  logic [7:0]         prio_r;

  logic [7:0]         fallback_r;
  logic [CNT_W-1:0]   live_r;
  logic [SLOT_COUNT-1:0] valid_r;

  // slot counter and read pipeline
  logic [CNT_W-1:0] cnt_r;
  logic             proc_vld_r;
  logic [IDX_W-1:0] proc_idx_r;
  logic             rd_en;
  logic             pass_done;

  // lookup results of the scan pass
  logic fa_r, fb_r, ffree_r, fsnd_r;
  logic [IDX_W-1:0] sa_r, sb_r, free_r, snd_r;
  rec_t ra_r, rb_r;
  logic [ID_BITS-1:0] snd_id_r;

  // decisions taken between the passes
  status_t            dec_status_r, d_status;
  logic [ID_BITS-1:0] dec_rt_r, d_rt;
  logic               dec_tk_r, d_tk;
  logic               wa_en_r, d_wa_en, wa_used_r, d_wa_used;
  rec_t               wa_rec_r, d_wa_rec;
  logic               wb_en_r, d_wb_en;
  rec_t               wb_rec_r, d_wb_rec;
  logic               ws_en_r, d_ws_en;
  logic               wn_en_r, d_wn_en;
  rec_t               wn_rec_r, d_wn_rec;
  logic               ex_en_r, d_ex_en;
  logic [CNT_W-1:0]   d_live;
  logic               deliver;

  // sweep accumulators
  logic [CNT_W-1:0] rel_r;
  logic             ffin_r;
  rec_t             rfin_r;
  logic [7:0]       maxo_r;

  // output register
  logic [OUT_W-1:0] out_word_r;
  logic             out_vld_r;

  rec_t ram_rdata_rec;
  logic [REC_W-1:0] ram_rdata;
  rec_t o, n;
  logic used, n_used, wake_hit;

  logic a_zero, b_zero;
  logic [7:0] eff;

  assign a_zero = (a_r == '0);
  assign b_zero = (b_r == '0);

  assign in_tready  = (phase_r == PH_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_DW'(out_word_r);

  assign rd_en     = ((phase_r == PH_SCAN) || (phase_r == PH_SWEEP)) &&
                     (cnt_r < CNT_W'(SLOT_COUNT));
  assign pass_done = (cnt_r == CNT_W'(SLOT_COUNT)) && !proc_vld_r;

  assign ram_rdata_rec = rec_t'(ram_rdata);
  assign used = valid_r[proc_idx_r];
  // a slot that is not occupied reads as all zeros
  assign o = used ? ram_rdata_rec : rec_t'('0);

  rit_ram #(
    .WIDTH (REC_W),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk   (clk),
    .we    ((phase_r == PH_SWEEP) && proc_vld_r),
    .waddr (proc_idx_r),
    .wdata (n),
    .re    (rd_en),
    .raddr (cnt_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // new value of the slot under the sweep
  always_comb begin
    n        = o;
    n_used   = used;
    wake_hit = 1'b0;
    // exit releases every thread blocked on the leaving one
    if (ex_en_r && used && (o.id != a_r) && (o.partner == a_r) &&
        ((o.state == TS_SEND_BLK) || (o.state == TS_REPLY_BLK) ||
         (o.state == TS_RECV_BLK))) begin
      n.state   = TS_READY;
      n.partner = '0;
      n.wake    = WK_PEER_EXITED;
      wake_hit  = 1'b1;
    end
    if (wa_en_r && (proc_idx_r == sa_r)) begin
      n      = wa_rec_r;
      n_used = wa_used_r;
    end
    if (wb_en_r && (proc_idx_r == sb_r)) begin
      n = wb_rec_r;
    end
    if (ws_en_r && (proc_idx_r == snd_r)) begin
      n.state = TS_REPLY_BLK;
    end
    if (wn_en_r && (proc_idx_r == free_r)) begin
      n      = wn_rec_r;
      n_used = 1'b1;
    end
  end

  // operation decode on the scanned records
  always_comb begin
    d_status  = ST_OK;
    d_rt      = '0;
    d_tk      = 1'b0;
    d_wa_en   = 1'b0;
    d_wa_used = 1'b1;
    d_wa_rec  = ra_r;
    d_wb_en   = 1'b0;
    d_wb_rec  = rb_r;
    d_ws_en   = 1'b0;
    d_wn_en   = 1'b0;
    d_wn_rec  = '{id: a_r, state: TS_READY, partner: '0, wake: WK_NONE, base: prio_r};
    d_ex_en   = 1'b0;
    d_live    = live_r;
    deliver   = fb_r && (rb_r.state == TS_RECV_BLK) && (rb_r.partner == '0);
    unique case (op_r) inside
      OP_CREATE, OP_CREATE_ADM: begin
        if (a_zero) d_status = ST_INVALID;
        else if (fa_r) d_status = ST_EXISTS;
        else if (!ffree_r) d_status = ST_FULL;
        else begin
          d_wn_en = 1'b1;
          d_wn_rec.state = (op_r == OP_CREATE) ? TS_READY : TS_ADMITTED;
          d_live = live_r + 1'b1;
        end
      end
      OP_START: begin
        if (!fa_r) d_status = ST_UNKNOWN;
        else if (ra_r.state != TS_ADMITTED) d_status = ST_NOT_RUNNABLE;
        else begin
          d_wa_en = 1'b1;
          d_wa_rec.state = TS_READY;
        end
      end
      OP_EXIT: begin
        if (!fa_r) d_status = ST_UNKNOWN;
        else begin
          d_ex_en   = 1'b1;
          d_wa_en   = 1'b1;
          d_wa_used = 1'b0;
          d_wa_rec  = '0;
          d_live    = live_r - 1'b1;
        end
      end
      OP_SEND: begin
        if (a_zero || b_zero) d_status = ST_INVALID;
        else if (a_r == b_r) d_status = ST_SELF;
        else if (!fa_r || !fb_r) d_status = ST_UNKNOWN;
        else if (ra_r.state != TS_READY) d_status = ST_NOT_RUNNABLE;
        else begin
          d_wa_en = 1'b1;
          d_wa_rec.wake    = WK_NONE;
          d_wa_rec.partner = b_r;
          d_wa_rec.state   = deliver ? TS_REPLY_BLK : TS_SEND_BLK;
          if (deliver) begin
            d_wb_en = 1'b1;
            d_wb_rec.state   = TS_READY;
            d_wb_rec.partner = a_r;
          end
        end
      end
      OP_RECEIVE: begin
        if (a_zero) d_status = ST_INVALID;
        else if (!fa_r) d_status = ST_UNKNOWN;
        else if (ra_r.state != TS_READY) d_status = ST_NOT_RUNNABLE;
        else begin
          d_wa_en = 1'b1;
          d_wa_rec.wake = WK_NONE;
          if (ra_r.partner != '0) begin
            d_rt = ra_r.partner;
            d_wa_rec.partner = '0;
          end else if (fsnd_r) begin
            d_ws_en = 1'b1;
            d_rt    = snd_id_r;
          end else begin
            d_wa_rec.state = TS_RECV_BLK;
          end
        end
      end
      OP_REPLY: begin
        if (a_zero || b_zero) d_status = ST_INVALID;
        else if (a_r == b_r) d_status = ST_SELF;
        else if (!fa_r || !fb_r) d_status = ST_UNKNOWN;
        else if ((rb_r.state != TS_REPLY_BLK) || (rb_r.partner != a_r))
          d_status = ST_NOT_AWAITING;
        else begin
          d_wb_en = 1'b1;
          d_wb_rec.state   = TS_READY;
          d_wb_rec.partner = '0;
          d_wb_rec.wake    = WK_REPLIED;
        end
      end
      OP_CANCEL_CALL: begin
        if (a_zero || b_zero) d_status = ST_INVALID;
        else if (!fa_r || !fb_r) d_status = ST_UNKNOWN;
        else if (!(((ra_r.state == TS_SEND_BLK) || (ra_r.state == TS_REPLY_BLK)) &&
                   (ra_r.partner == b_r))) d_status = ST_NOT_WAITING;
        else begin
          d_wa_en = 1'b1;
          d_wa_rec.state   = TS_READY;
          d_wa_rec.partner = '0;
          d_wa_rec.wake    = WK_RETIRED;
          // server still holds the undelivered call: drop it
          if ((rb_r.state == TS_READY) && (rb_r.partner == a_r)) begin
            d_wb_en = 1'b1;
            d_wb_rec.partner = '0;
          end
        end
      end
      OP_CANCEL_RECV, OP_EXPIRE_RECV: begin
        if (a_zero) d_status = ST_INVALID;
        else if (!fa_r) d_status = ST_UNKNOWN;
        else if ((ra_r.state != TS_RECV_BLK) || (ra_r.partner != '0))
          d_status = ST_NOT_WAITING;
        else begin
          d_wa_en = 1'b1;
          d_wa_rec.state = TS_READY;
          d_wa_rec.wake  = (op_r == OP_CANCEL_RECV) ? WK_RETIRED : WK_DEADLINE;
        end
      end
      OP_TAKE_EXPIRY: begin
        if (a_zero) d_status = ST_INVALID;
        else if (!fa_r) d_status = ST_UNKNOWN;
        else if (ra_r.wake == WK_DEADLINE) begin
          d_wa_en = 1'b1;
          d_wa_rec.wake = WK_NONE;
          d_tk = 1'b1;
        end
      end
      default: begin
        // query, also for the unused opcodes
        if (!fa_r) d_status = ST_UNKNOWN;
        else d_rt = ra_r.partner;
      end
    endcase
  end

  // effective priority of thread_a after the step
  always_comb begin
    if (!ffin_r) eff = fallback_r;
    else if (maxo_r > rfin_r.base) eff = maxo_r;
    else eff = rfin_r.base;
  end

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_IDLE:   if (in_tvalid) phase_nxt = PH_SCAN;
      PH_SCAN:   if (pass_done) phase_nxt = PH_DECIDE;
      PH_DECIDE: phase_nxt = PH_SWEEP;
      PH_SWEEP:  if (pass_done) phase_nxt = PH_FIN;
      PH_FIN:    if (!out_vld_r || out_tready) phase_nxt = PH_IDLE;
      default:   phase_nxt = PH_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      fallback_r <= '0;
      live_r     <= '0;
      valid_r    <= '0;
      cnt_r      <= '0;
      proc_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      proc_vld_r <= rd_en;
      if (cfg_wr_en) fallback_r <= cfg_wr_data;
      if (rd_en) cnt_r <= cnt_r + 1'b1;
      else if ((phase_r == PH_DECIDE) || (phase_r == PH_IDLE)) cnt_r <= '0;
      if (phase_r == PH_DECIDE) live_r <= d_live;
      if ((phase_r == PH_SWEEP) && proc_vld_r) valid_r[proc_idx_r] <= n_used;
      if ((phase_r == PH_FIN) && (!out_vld_r || out_tready)) out_vld_r <= 1'b1;
      else if (out_vld_r && out_tready) out_vld_r <= 1'b0;
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    proc_idx_r <= cnt_r[IDX_W-1:0];
    if (in_tvalid && in_tready) begin
      op_r    <= in_tdata[3:0];
      a_r     <= in_tdata[4 +: ID_BITS];
      b_r     <= in_tdata[4 + ID_BITS +: ID_BITS];
      prio_r  <= in_tdata[4 + 2 * ID_BITS +: 8];
      fa_r    <= 1'b0;
      fb_r    <= 1'b0;
      ffree_r <= 1'b0;
      fsnd_r  <= 1'b0;
      ra_r    <= '0;
      rb_r    <= '0;
    end
    if ((phase_r == PH_SCAN) && proc_vld_r) begin
      if (used && !a_zero && (o.id == a_r)) begin
        fa_r <= 1'b1;
        sa_r <= proc_idx_r;
        ra_r <= o;
      end
      if (used && !b_zero && (o.id == b_r)) begin
        fb_r <= 1'b1;
        sb_r <= proc_idx_r;
        rb_r <= o;
      end
      if (!used && !ffree_r) begin
        ffree_r <= 1'b1;
        free_r  <= proc_idx_r;
      end
      // first sender blocked on thread_a, in slot order
      if (used && (o.state == TS_SEND_BLK) && (o.partner == a_r) && !fsnd_r) begin
        fsnd_r   <= 1'b1;
        snd_r    <= proc_idx_r;
        snd_id_r <= o.id;
      end
    end
    if (phase_r == PH_DECIDE) begin
      dec_status_r <= d_status;
      dec_rt_r     <= d_rt;
      dec_tk_r     <= d_tk;
      wa_en_r      <= d_wa_en;
      wa_used_r    <= d_wa_used;
      wa_rec_r     <= d_wa_rec;
      wb_en_r      <= d_wb_en;
      wb_rec_r     <= d_wb_rec;
      ws_en_r      <= d_ws_en;
      wn_en_r      <= d_wn_en;
      wn_rec_r     <= d_wn_rec;
      ex_en_r      <= d_ex_en;
      rel_r        <= '0;
      ffin_r       <= 1'b0;
      rfin_r       <= '0;
      maxo_r       <= '0;
    end
    if ((phase_r == PH_SWEEP) && proc_vld_r) begin
      if (wake_hit) rel_r <= rel_r + 1'b1;
      // inheritance over the updated table
      if (n_used && !a_zero && (n.id == a_r)) begin
        ffin_r <= 1'b1;
        rfin_r <= n;
      end else if (n_used && (n.partner == a_r) && (n.base > maxo_r) &&
                   ((n.state == TS_SEND_BLK) || (n.state == TS_REPLY_BLK))) begin
        maxo_r <= n.base;
      end
    end
    if ((phase_r == PH_FIN) && (!out_vld_r || out_tready)) begin
      out_word_r <= {live_r, eff, rfin_r.base, rfin_r.wake, rfin_r.state,
                     dec_tk_r, rel_r, dec_rt_r, dec_status_r};
    end
  end

endmodule

// File: design/rit_ram.sv
`timescale 1ns / 1ps
module rit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/rit_checker.sv
`timescale 1ns / 1ps
module rit_checker #(
  parameter int SLOT_COUNT = 16,
  parameter int ID_BITS    = 16,
  localparam int CNT_W  = $clog2(SLOT_COUNT + 1),
  localparam int OUT_W  = 4 + ID_BITS + CNT_W + 1 + 3 + 3 + 8 + 8 + CNT_W,
  localparam int OUT_DW = ((OUT_W + 7) / 8) * 8
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic [OUT_DW-1:0] out_tdata,
  input logic              out_tvalid,
  input logic              out_tready
);
  import rit_pkg::*;

  localparam int REL_LO  = 4 + ID_BITS;
  localparam int TK_LO   = REL_LO + CNT_W;
  localparam int LIVE_LO = TK_LO + 1 + 3 + 3 + 8 + 8;

  status_t            o_status;
  logic [ID_BITS-1:0] o_rt;
  logic [CNT_W-1:0]   o_rel, o_live;
  logic               o_tk;

  assign o_status = out_tdata[3:0];
  assign o_rt     = out_tdata[4 +: ID_BITS];
  assign o_rel    = out_tdata[REL_LO +: CNT_W];
  assign o_tk     = out_tdata[TK_LO];
  assign o_live   = out_tdata[LIVE_LO +: CNT_W];

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word taken while one is in work");

  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (o_status != ST_OK) |-> (o_rt == '0) && (o_rel == '0) && !o_tk)
    else $error("failed operation reports side results");

  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (o_live <= CNT_W'(SLOT_COUNT)) && (o_rel < CNT_W'(SLOT_COUNT)))
    else $error("live or released count beyond table size");

endmodule

bind rendezvous_ipc_thread_table rit_checker #(
  .SLOT_COUNT (SLOT_COUNT),
  .ID_BITS    (ID_BITS)
) u_rit_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
